// File: hw/rtl/sdtq_pkg.sv
// ----------------------------------------------------------------------------
// Sleep delta timer queue package
// Shared widths, reset values, codes and the command word that drives the
// row of queue cells.
// ----------------------------------------------------------------------------
package sdtq_pkg;

   localparam int unsigned QueueDepthDefault = 16;
   localparam int unsigned IdWidth           = 10;
   localparam int unsigned TimeWidth         = 32;
   localparam int unsigned CfgWidth          = 10;
   localparam int unsigned StatusWidth       = 3;

   // A tick delivers at most this many woken processes.
   localparam int unsigned MaxWake           = 16;
   localparam int unsigned WakeCntWidth      = $clog2(MaxWake);

   localparam logic [CfgWidth-1:0] MsPerTickReset = 10'd10;
   localparam logic [IdWidth-1:0]  IdleIdReset    = 10'd999;

   // The divider retires this many quotient bits per clock.
   localparam int unsigned DivStepsPerCycle  = 2;
   localparam int unsigned DivCycles         = TimeWidth / DivStepsPerCycle;
   localparam int unsigned DivCntWidth       = $clog2(DivCycles);

   typedef enum logic [StatusWidth-1:0] {
      STATUS_INSERTED = 3'd0,
      STATUS_FULL     = 3'd1,
      STATUS_IDLE     = 3'd2,
      STATUS_WOKEN    = 3'd3,
      STATUS_NONE     = 3'd4
   } status_type;

   typedef enum logic {
      FUNC_INSERT = 1'b0,
      FUNC_TICK   = 1'b1
   } func_type;

   typedef enum logic {
      CSR_MS_PER_TICK = 1'b0,
      CSR_IDLE_ID     = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      STATE_IDLE,
      STATE_DIVIDE,
      STATE_INSERT,
      STATE_TICK,
      STATE_WAKE
   } state_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_DEC,
      CELL_INSERT,
      CELL_SHIFT
   } cell_op_type;

   typedef struct packed {
      cell_op_type          op;
      logic [IdWidth-1:0]   id;
      logic [TimeWidth-1:0] ticks;
   } cell_cmd_type;

endpackage

// File: hw/rtl/sdtq_tick_div.sv
// ----------------------------------------------------------------------------
// Millisecond to tick converter
// Restoring divider, two quotient bits per clock, that rounds the quotient
// up and never returns fewer than one tick.
// ----------------------------------------------------------------------------
module sdtq_tick_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [sdtq_pkg::TimeWidth-1:0]     dividend,
   input  logic [sdtq_pkg::CfgWidth-1:0]      divisor,
   output logic                               done,
   output logic [sdtq_pkg::TimeWidth-1:0]     ticks
);

   localparam int unsigned TW = sdtq_pkg::TimeWidth;
   localparam int unsigned CW = sdtq_pkg::CfgWidth;
   localparam int unsigned NW = sdtq_pkg::DivCntWidth;

   logic          busy_ff, busy_in;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic [TW-1:0] quo_ff, quo_in;
   logic [CW-1:0] rem_ff, rem_in;
   logic [CW-1:0] den_ff, den_in;
   logic [TW-1:0] rounded;

   always_comb begin
      logic [CW-1:0] r;
      logic [TW-1:0] q;
      logic [CW:0]   t;
      r = rem_ff;
      q = quo_ff;
      t = '0;
      for (int s = 0; s < sdtq_pkg::DivStepsPerCycle; s++) begin
         t = {r, q[TW-1]};
         q = {q[TW-2:0], 1'b0};
         if (t >= {1'b0, den_ff}) begin
            t    = t - {1'b0, den_ff};
            q[0] = 1'b1;
         end
         r = t[CW-1:0];
      end
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         // A zero tick period counts as one millisecond.
         den_in  = (divisor == '0) ? CW'(1) : divisor;
      end else if (busy_ff) begin
         quo_in = q;
         rem_in = r;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == NW'(sdtq_pkg::DivCycles - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done    = busy_ff && (cnt_ff == NW'(sdtq_pkg::DivCycles - 1));
   assign rounded = quo_ff + TW'(rem_ff != '0);
   assign ticks   = (rounded == '0) ? TW'(1) : rounded;

endmodule

// File: hw/rtl/sdtq_cell.sv
// ----------------------------------------------------------------------------
// Sleep queue cell
// One queue slot: a process id and its wake time counted from now. Slots
// shift toward the head on a wake and toward the tail on an insert.
// ----------------------------------------------------------------------------
module sdtq_cell (
   input  logic                           clock,
   input  sdtq_pkg::cell_cmd_type         cmd,
   input  logic                           occupied,
   input  logic                           prev_ge,
   input  logic [sdtq_pkg::IdWidth-1:0]   prev_id,
   input  logic [sdtq_pkg::TimeWidth-1:0] prev_cum,
   input  logic [sdtq_pkg::IdWidth-1:0]   next_id,
   input  logic [sdtq_pkg::TimeWidth-1:0] next_cum,
   output logic                           ge,
   output logic [sdtq_pkg::IdWidth-1:0]   id,
   output logic [sdtq_pkg::TimeWidth-1:0] cum
);

   logic [sdtq_pkg::IdWidth-1:0]   id_ff, id_in;
   logic [sdtq_pkg::TimeWidth-1:0] cum_ff, cum_in;

   // The new process goes behind every entry that wakes at the same tick or
   // earlier, so an occupied slot stays put when its time is not later.
   assign ge = occupied && (cmd.ticks >= cum_ff);

   always_comb begin
      id_in  = id_ff;
      cum_in = cum_ff;
      unique case (cmd.op)
         sdtq_pkg::CELL_HOLD: begin
         end
         sdtq_pkg::CELL_DEC: begin
            cum_in = cum_ff - 1'b1;
         end
         sdtq_pkg::CELL_INSERT: begin
            if (!ge) begin
               if (prev_ge) begin
                  id_in  = cmd.id;
                  cum_in = cmd.ticks;
               end else begin
                  id_in  = prev_id;
                  cum_in = prev_cum;
               end
            end
         end
         sdtq_pkg::CELL_SHIFT: begin
            id_in  = next_id;
            cum_in = next_cum;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      id_ff  <= id_in;
      cum_ff <= cum_in;
   end

   assign id  = id_ff;
   assign cum = cum_ff;

endmodule

// File: hw/rtl/sleep_delta_timer_queue.sv
// ----------------------------------------------------------------------------
// Sleep delta timer queue
// Sorted sleep queue of process ids. Inserts convert milliseconds to ticks
// and place the process in wake order; ticks wake due processes, up to MaxWake.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake           Word
//   req      in         req_valid/req_stall  func, proc_id, duration_ms
//   rsp      out        rsp_valid/rsp_stall  status, woken_id, last
//   csr      in         csr_valid/csr_ready  index, data (always ready)
//
// An insert is accepted, converted to ticks in the tick divider (two
// quotient bits per clock) and then placed. A refused insert skips the
// divider. A tick lowers the times and then sends one response word per
// woken process, or a single none word when nothing is due.
// Reset clears the control state and the entry count; the cells need no
// clearing pass. A stalled rsp word holds the block in its current step,
// and req is stalled whenever an item is still being worked on.
//
module sleep_delta_timer_queue #(
   parameter int unsigned QUEUE_DEPTH = sdtq_pkg::QueueDepthDefault
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_func,
   input  logic [sdtq_pkg::IdWidth-1:0]       req_proc_id,
   input  logic [sdtq_pkg::TimeWidth-1:0]     req_duration_ms,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [sdtq_pkg::StatusWidth-1:0]   rsp_status,
   output logic [sdtq_pkg::IdWidth-1:0]       rsp_woken_id,
   output logic                               rsp_last,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic                               csr_index,
   input  logic [sdtq_pkg::CfgWidth-1:0]      csr_data
);

   localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned IW = sdtq_pkg::IdWidth;
   localparam int unsigned TW = sdtq_pkg::TimeWidth;
   localparam int unsigned NW = sdtq_pkg::WakeCntWidth;

   // Configuration registers.
   logic [sdtq_pkg::CfgWidth-1:0] ms_per_tick_ff;
   logic [IW-1:0]                 idle_id_ff;

   // Control state.
   sdtq_pkg::state_type  state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [NW-1:0]        wake_n_ff, wake_n_in;
   logic                 refuse_ff, refuse_in;
   sdtq_pkg::status_type pend_status_ff, pend_status_in;
   logic [IW-1:0]        req_id_ff;

   // Output register.
   logic                 rsp_valid_ff, rsp_valid_in;
   sdtq_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [IW-1:0]        rsp_woken_id_ff, rsp_woken_id_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                   div_start;
   logic                   div_done;
   logic [TW-1:0]          div_ticks;
   sdtq_pkg::cell_cmd_type cell_cmd;

   logic [IW-1:0]          cell_id  [QUEUE_DEPTH];
   logic [TW-1:0]          cell_cum [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] cell_ge;
   logic [QUEUE_DEPTH-1:0] cell_occupied;

   logic out_free;
   logic wake_now;
   logic wake_more;

   // The divider turns the sleep length into ticks while the queue waits.
   sdtq_tick_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_duration_ms),
      .divisor  (ms_per_tick_ff),
      .done     (div_done),
      .ticks    (div_ticks)
   );

   // Each cell stores its wake time counted from now rather than from the
   // entry ahead of it. The running sums of the delta list then sit in the
   // cells, so every cell finds its side of the insertion point on its own,
   // and a tick lowers all times together.
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic          prev_ge;
      logic [IW-1:0] prev_id;
      logic [TW-1:0] prev_cum;
      logic [IW-1:0] next_id;
      logic [TW-1:0] next_cum;

      assign cell_occupied[i] = (count_ff > CW'(i));

      if (i == 0) begin : g_head
         assign prev_ge  = 1'b1;
         assign prev_id  = cell_cmd.id;
         assign prev_cum = cell_cmd.ticks;
      end else begin : g_body
         assign prev_ge  = cell_ge[i-1];
         assign prev_id  = cell_id[i-1];
         assign prev_cum = cell_cum[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign next_id  = cell_id[i];
         assign next_cum = cell_cum[i];
      end else begin : g_inner
         assign next_id  = cell_id[i+1];
         assign next_cum = cell_cum[i+1];
      end

      sdtq_cell u_cell (
         .clock    (clock),
         .cmd      (cell_cmd),
         .occupied (cell_occupied[i]),
         .prev_ge  (prev_ge),
         .prev_id  (prev_id),
         .prev_cum (prev_cum),
         .next_id  (next_id),
         .next_cum (next_cum),
         .ge       (cell_ge[i]),
         .id       (cell_id[i]),
         .cum      (cell_cum[i])
      );
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // The head wakes when its time has reached zero. Another wake follows
   // when the second entry is due as well and the per-tick limit allows it.
   assign wake_now  = (count_ff != '0) && (cell_cum[0] == '0);
   assign wake_more = (count_ff > CW'(1)) && (cell_cum[1] == '0) &&
                      (wake_n_ff != NW'(sdtq_pkg::MaxWake - 1));

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      wake_n_in       = wake_n_ff;
      refuse_in       = refuse_ff;
      pend_status_in  = pend_status_ff;
      div_start       = 1'b0;
      cell_cmd.op     = sdtq_pkg::CELL_HOLD;
      cell_cmd.id     = req_id_ff;
      cell_cmd.ticks  = div_ticks;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_status_in   = rsp_status_ff;
      rsp_woken_id_in = rsp_woken_id_ff;
      rsp_last_in     = rsp_last_ff;

      unique case (state_ff)
         sdtq_pkg::STATE_IDLE: begin
            if (req_valid) begin
               priority if (req_func == sdtq_pkg::FUNC_TICK) begin
                  state_in = sdtq_pkg::STATE_TICK;
               end else if (req_proc_id == idle_id_ff) begin
                  // The idle process check comes before the full check.
                  refuse_in      = 1'b1;
                  pend_status_in = sdtq_pkg::STATUS_IDLE;
                  state_in       = sdtq_pkg::STATE_INSERT;
               end else if (count_ff == CW'(QUEUE_DEPTH)) begin
                  refuse_in      = 1'b1;
                  pend_status_in = sdtq_pkg::STATUS_FULL;
                  state_in       = sdtq_pkg::STATE_INSERT;
               end else begin
                  refuse_in      = 1'b0;
                  pend_status_in = sdtq_pkg::STATUS_INSERTED;
                  div_start      = 1'b1;
                  state_in       = sdtq_pkg::STATE_DIVIDE;
               end
            end
         end
         sdtq_pkg::STATE_DIVIDE: begin
            if (div_done) begin
               state_in = sdtq_pkg::STATE_INSERT;
            end
         end
         sdtq_pkg::STATE_INSERT: begin
            if (out_free) begin
               if (!refuse_ff) begin
                  cell_cmd.op = sdtq_pkg::CELL_INSERT;
                  count_in    = count_ff + 1'b1;
               end
               rsp_valid_in    = 1'b1;
               rsp_status_in   = pend_status_ff;
               rsp_woken_id_in = '0;
               rsp_last_in     = 1'b1;
               state_in        = sdtq_pkg::STATE_IDLE;
            end
         end
         sdtq_pkg::STATE_TICK: begin
            // A head already at zero is not lowered, so times never wrap.
            if ((count_ff != '0) && (cell_cum[0] != '0)) begin
               cell_cmd.op = sdtq_pkg::CELL_DEC;
            end
            wake_n_in = '0;
            state_in  = sdtq_pkg::STATE_WAKE;
         end
         sdtq_pkg::STATE_WAKE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (wake_now) begin
                  cell_cmd.op     = sdtq_pkg::CELL_SHIFT;
                  count_in        = count_ff - 1'b1;
                  wake_n_in       = wake_n_ff + 1'b1;
                  rsp_status_in   = sdtq_pkg::STATUS_WOKEN;
                  rsp_woken_id_in = cell_id[0];
                  rsp_last_in     = !wake_more;
                  if (!wake_more) begin
                     state_in = sdtq_pkg::STATE_IDLE;
                  end
               end else begin
                  // Only reached on the first step: nothing was due.
                  rsp_status_in   = sdtq_pkg::STATUS_NONE;
                  rsp_woken_id_in = '0;
                  rsp_last_in     = 1'b1;
                  state_in        = sdtq_pkg::STATE_IDLE;
               end
            end
         end
         default: begin
            state_in = sdtq_pkg::STATE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= sdtq_pkg::STATE_IDLE;
         count_ff       <= '0;
         wake_n_ff      <= '0;
         refuse_ff      <= 1'b0;
         pend_status_ff <= sdtq_pkg::STATUS_INSERTED;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         wake_n_ff      <= wake_n_in;
         refuse_ff      <= refuse_in;
         pend_status_ff <= pend_status_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_status_ff   <= rsp_status_in;
      rsp_woken_id_ff <= rsp_woken_id_in;
      rsp_last_ff     <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if ((state_ff == sdtq_pkg::STATE_IDLE) && req_valid) begin
         req_id_ff <= req_proc_id;
      end
   end

   // Configuration writes must arrive only while the block is idle; the block itself does not enforce this.
   always_ff @(posedge clock) begin
      if (reset) begin
         ms_per_tick_ff <= sdtq_pkg::MsPerTickReset;
         idle_id_ff     <= sdtq_pkg::IdleIdReset;
      end else if (csr_valid && csr_ready) begin
         unique case (sdtq_pkg::csr_index_type'(csr_index))
            sdtq_pkg::CSR_MS_PER_TICK: ms_per_tick_ff <= csr_data;
            sdtq_pkg::CSR_IDLE_ID:     idle_id_ff     <= csr_data;
         endcase
      end
   end

   assign req_stall    = (state_ff != sdtq_pkg::STATE_IDLE);
   assign csr_ready    = 1'b1;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_woken_id = rsp_woken_id_ff;
   assign rsp_last     = rsp_last_ff;

   // The queue never holds more entries than it has cells.
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == sdtq_pkg::STATE_INSERT) |-> (count_ff <= CW'(QUEUE_DEPTH)))
      else $error("entry count above queue depth");

   // A placed insert grows the queue by exactly one entry.
   a_insert_count : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == sdtq_pkg::STATE_INSERT) && out_free && !refuse_ff) |=>
      (count_ff == CW'($past(count_ff) + 1'b1)))
      else $error("insert did not add one entry");

   // Every woken word removes exactly one entry from the head.
   a_wake_count : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == sdtq_pkg::STATE_WAKE) && out_free && wake_now) |=>
      ((count_ff == CW'($past(count_ff) - 1'b1)) &&
       (rsp_status == sdtq_pkg::STATUS_WOKEN)))
      else $error("wake did not remove one entry");

   // The divider only finishes while an insert waits for it.
   a_div_done : assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == sdtq_pkg::STATE_DIVIDE))
      else $error("divider finished outside an insert");

endmodule

// File: tb/sleep_delta_timer_queue_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sleep delta timer queue testbench
// Drives insert and tick words into the queue under several tick periods,
// idle ids and flow-control patterns. A wake-order tracker keeps its own
// delta list and checks every response word in order.
// ----------------------------------------------------------------------------

class wake_order_tracker;

   typedef struct packed {
      sdtq_pkg::status_type              status;
      logic [sdtq_pkg::IdWidth-1:0]      woken_id;
      logic                              last;
   } wake_word_type;

   logic [sdtq_pkg::CfgWidth-1:0]  ms_per_tick;
   logic [sdtq_pkg::IdWidth-1:0]   idle_id;
   logic [sdtq_pkg::IdWidth-1:0]   slot_id [sdtq_pkg::QueueDepthDefault];
   logic [sdtq_pkg::TimeWidth-1:0] slot_delta [sdtq_pkg::QueueDepthDefault];
   int unsigned                    slot_count;
   wake_word_type                  due_words [$];
   int unsigned                    mismatches;

   function new();
      ms_per_tick = sdtq_pkg::MsPerTickReset;
      idle_id     = sdtq_pkg::IdleIdReset;
      slot_count  = 0;
      mismatches  = 0;
   endfunction

   function void set_reg(sdtq_pkg::csr_index_type index, logic [sdtq_pkg::CfgWidth-1:0] value);
      if (index == sdtq_pkg::CSR_MS_PER_TICK) begin
         ms_per_tick = value;
      end else begin
         idle_id = value;
      end
   endfunction

   function void push_word(sdtq_pkg::status_type status, logic [sdtq_pkg::IdWidth-1:0] id,
                           logic last);
      wake_word_type w;
      w.status   = status;
      w.woken_id = id;
      w.last     = last;
      due_words.push_back(w);
   endfunction

   // Work out the response words of one accepted request word.
   function void note_word(sdtq_pkg::func_type func, logic [sdtq_pkg::IdWidth-1:0] proc_id,
                           logic [sdtq_pkg::TimeWidth-1:0] duration_ms);
      logic [31:0] per;
      logic [31:0] ticks;
      logic [63:0] cum;
      int unsigned pos;
      int unsigned i;
      int unsigned woke;
      logic        final_one;
      if (func == sdtq_pkg::FUNC_INSERT) begin
         if (proc_id == idle_id) begin
            push_word(sdtq_pkg::STATUS_IDLE, '0, 1'b1);
         end else if (slot_count >= sdtq_pkg::QueueDepthDefault) begin
            push_word(sdtq_pkg::STATUS_FULL, '0, 1'b1);
         end else begin
            per   = (ms_per_tick == 0) ? 32'd1 : {22'd0, ms_per_tick};
            ticks = duration_ms / per + ((duration_ms % per != 0) ? 32'd1 : 32'd0);
            if (ticks == 0) ticks = 32'd1;
            // Walk the cumulative wake times; ties go behind existing entries.
            cum = 64'd0;
            pos = 0;
            while (pos < slot_count && {32'd0, ticks} >= cum + {32'd0, slot_delta[pos]}) begin
               cum = cum + {32'd0, slot_delta[pos]};
               pos++;
            end
            for (i = slot_count; i > pos; i--) begin
               slot_id[i]    = slot_id[i-1];
               slot_delta[i] = slot_delta[i-1];
            end
            slot_id[pos]    = proc_id;
            slot_delta[pos] = ticks - cum[31:0];
            if (pos + 1 <= slot_count) slot_delta[pos+1] = slot_delta[pos+1] - slot_delta[pos];
            slot_count++;
            push_word(sdtq_pkg::STATUS_INSERTED, '0, 1'b1);
         end
      end else if (slot_count == 0) begin
         push_word(sdtq_pkg::STATUS_NONE, '0, 1'b1);
      end else begin
         if (slot_delta[0] != 0) slot_delta[0] = slot_delta[0] - 32'd1;
         woke = 0;
         while (slot_count > 0 && slot_delta[0] == 0 && woke < sdtq_pkg::MaxWake) begin
            final_one = (slot_count == 1) || (slot_delta[1] != 0) ||
                        (woke + 1 == sdtq_pkg::MaxWake);
            push_word(sdtq_pkg::STATUS_WOKEN, slot_id[0], final_one);
            woke++;
            for (i = 1; i < slot_count; i++) begin
               slot_id[i-1]    = slot_id[i];
               slot_delta[i-1] = slot_delta[i];
            end
            slot_count--;
         end
         if (woke == 0) push_word(sdtq_pkg::STATUS_NONE, '0, 1'b1);
      end
   endfunction

   // Compare one accepted response word with the oldest expectation.
   function void check_word(logic [sdtq_pkg::StatusWidth-1:0] status,
                            logic [sdtq_pkg::IdWidth-1:0] id, logic last);
      wake_word_type want;
      if (due_words.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected word: status %0d id %0d last %0d", status, id, last);
         return;
      end
      want = due_words.pop_front();
      if (want.status !== status || want.woken_id !== id || want.last !== last) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: expected status %0d id %0d last %0d, got status %0d id %0d last %0d",
                     want.status, want.woken_id, want.last, status, id, last);
      end
   endfunction

endclass

module sleep_delta_timer_queue_tb;

   // The limit only catches a hung handshake; a normal run stays well below
   // it even with heavy stalling.
   localparam int unsigned CycleLimit = 400000;
   localparam int unsigned HoldCycles = 400;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   logic                                 req_func = sdtq_pkg::FUNC_INSERT;
   logic [sdtq_pkg::IdWidth-1:0]         req_proc_id = '0;
   logic [sdtq_pkg::TimeWidth-1:0]       req_duration_ms = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   logic [sdtq_pkg::StatusWidth-1:0]     rsp_status;
   logic [sdtq_pkg::IdWidth-1:0]         rsp_woken_id;
   logic                                 rsp_last;
   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic                                 csr_index = sdtq_pkg::CSR_MS_PER_TICK;
   logic [sdtq_pkg::CfgWidth-1:0]        csr_data = '0;

   // Flow-control knobs for the current phase, in percent of cycles.
   int unsigned                          req_gap_pct = 0;
   int unsigned                          rsp_stall_pct = 0;
   logic                                 hold_rsp = 1'b0;
   int unsigned                          cycle_count = 0;
   logic [sdtq_pkg::TimeWidth-1:0]       prior_ms = '0;

   wake_order_tracker                    tracker = new();

   always #5 clock = ~clock;

   sleep_delta_timer_queue u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_proc_id     (req_proc_id),
      .req_duration_ms (req_duration_ms),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_woken_id    (rsp_woken_id),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   // Response side: every word taken at an edge is checked, then the stall
   // for the next edge is chosen. A long hold-off overrides the random stall.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) tracker.check_word(rsp_status, rsp_woken_id, rsp_last);
         rsp_stall <= hold_rsp || ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Offer one request word and wait until the queue takes it. Valid is left
   // high afterwards so that back-to-back words never lower and raise it in
   // the same step; a gap or a drain lowers it.
   task automatic send_word(sdtq_pkg::func_type func, logic [sdtq_pkg::IdWidth-1:0] proc_id,
                            logic [sdtq_pkg::TimeWidth-1:0] duration_ms);
      while ($urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_func        <= func;
      req_proc_id     <= proc_id;
      req_duration_ms <= duration_ms;
      do @(posedge clock); while (req_stall);
      tracker.note_word(func, proc_id, duration_ms);
   endtask

   // Stop offering words and wait until every expected word has come back.
   // Each request gives at least one response, so the settle wait afterwards
   // only has to let the block return to idle.
   task automatic finish_outstanding(int unsigned settle);
      req_valid <= 1'b0;
      while (tracker.due_words.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // Write both registers back to back while the queue is idle.
   task automatic program_regs(logic [sdtq_pkg::CfgWidth-1:0] tick_ms,
                               logic [sdtq_pkg::CfgWidth-1:0] idle_pid);
      csr_valid <= 1'b1;
      csr_index <= sdtq_pkg::CSR_MS_PER_TICK;
      csr_data  <= tick_ms;
      do @(posedge clock); while (!csr_ready);
      tracker.set_reg(sdtq_pkg::CSR_MS_PER_TICK, tick_ms);
      csr_index <= sdtq_pkg::CSR_IDLE_ID;
      csr_data  <= idle_pid;
      do @(posedge clock); while (!csr_ready);
      tracker.set_reg(sdtq_pkg::CSR_IDLE_ID, idle_pid);
      csr_valid <= 1'b0;
   endtask

   // One random word. Most inserts use short sleeps measured in the current
   // tick period so that ticks keep waking processes; a repeated duration
   // builds groups that wake on the same tick. Rare huge sleeps stay queued
   // for the rest of the run and push later inserts toward the full case.
   task automatic send_random_word();
      logic [sdtq_pkg::TimeWidth-1:0] per;
      logic [sdtq_pkg::TimeWidth-1:0] ms;
      logic [sdtq_pkg::IdWidth-1:0]   pid;
      int unsigned                    pick;
      per = (tracker.ms_per_tick == 0) ? 32'd1 : {22'd0, tracker.ms_per_tick};
      if ($urandom_range(99) < 42) begin
         send_word(sdtq_pkg::FUNC_TICK, sdtq_pkg::IdWidth'($urandom_range(1023)), $urandom());
      end else begin
         pid  = ($urandom_range(99) < 5) ? tracker.idle_id :
                sdtq_pkg::IdWidth'($urandom_range(1023));
         pick = $urandom_range(99);
         if (pick < 3) begin
            ms = $urandom();
         end else if (pick < 23) begin
            ms = prior_ms;
         end else if (pick < 35) begin
            ms = $urandom_range(40 * per);
         end else begin
            ms = $urandom_range(6 * per);
         end
         prior_ms = ms;
         send_word(sdtq_pkg::FUNC_INSERT, pid, ms);
      end
   endtask

   task automatic run_phase(logic [sdtq_pkg::CfgWidth-1:0] tick_ms,
                            logic [sdtq_pkg::CfgWidth-1:0] idle_pid,
                            int unsigned gap_pct, int unsigned stall_pct,
                            logic with_holdoff, int unsigned count);
      finish_outstanding(4);
      program_regs(tick_ms, idle_pid);
      req_gap_pct   = gap_pct;
      rsp_stall_pct = stall_pct;
      if (with_holdoff) begin
         // The receiver goes quiet for a long stretch while requests keep
         // coming, so the block backs up and stalls its input.
         fork
            begin
               repeat (15) @(posedge clock);
               hold_rsp <= 1'b1;
               repeat (HoldCycles) @(posedge clock);
               hold_rsp <= 1'b0;
            end
         join_none
      end
      repeat (count) send_random_word();
   endtask

   initial begin
      int unsigned k;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under the reset values of the registers: a tick on an
      // empty queue, the idle process, zero and maximum sleeps, the extreme
      // ids, ties that must queue behind earlier entries, a full queue, and
      // the idle check taking priority over the full check.
      send_word(sdtq_pkg::FUNC_TICK, '0, '0);
      send_word(sdtq_pkg::FUNC_INSERT, sdtq_pkg::IdleIdReset, 32'd5);
      send_word(sdtq_pkg::FUNC_INSERT, 10'd0, 32'd0);
      send_word(sdtq_pkg::FUNC_INSERT, 10'd1023, 32'hFFFF_FFFF);
      send_word(sdtq_pkg::FUNC_INSERT, 10'd5, 32'd10);
      send_word(sdtq_pkg::FUNC_INSERT, 10'd6, 32'd11);
      for (k = 0; k < 12; k++) begin
         send_word(sdtq_pkg::FUNC_INSERT, sdtq_pkg::IdWidth'(100 + k), 32'(7 * k));
      end
      send_word(sdtq_pkg::FUNC_INSERT, 10'd200, 32'd1);
      send_word(sdtq_pkg::FUNC_INSERT, sdtq_pkg::IdleIdReset, 32'd1);
      // The first tick wakes every process due after one tick, in order.
      send_word(sdtq_pkg::FUNC_TICK, '0, '0);
      send_word(sdtq_pkg::FUNC_TICK, '0, '0);
      send_word(sdtq_pkg::FUNC_TICK, '0, '0);

      // Random phases, each with its own tick period, idle id and flow
      // control. A period of zero behaves as one millisecond per tick.
      run_phase(10'd1, 10'd0, 0, 0, 1'b0, 38);
      run_phase(10'd1000, 10'd1023, 61, 0, 1'b0, 38);
      run_phase(10'd0, 10'($urandom_range(1023)), 0, 61, 1'b0, 38);
      run_phase(10'd7, sdtq_pkg::IdleIdReset, 18, 18, 1'b0, 38);
      run_phase(10'd3, 10'd12, 0, 0, 1'b1, 38);

      finish_outstanding(40);
      if (tracker.mismatches == 0 && tracker.due_words.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
